### rtl/tstl_pkg.sv
`timescale 1ns / 1ps

package tstl_pkg;

  // Default sizing of the table.
  localparam int SLOTS_DEF      = 8;
  localparam int ID_BYTES_DEF   = 8;
  localparam int STAMP_BITS_DEF = 32;

  // Port widths fixed by the interface.
  localparam int VID_BITS     = 64;
  localparam int SLOT_BITS    = 3;
  localparam int OUTCOME_BITS = 2;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 8;
  localparam int ACTIVE_BITS  = 4;

  // Register reset values.
  localparam logic [7:0]             SELF_TAG_RST = 8'd66;
  localparam logic [ACTIVE_BITS-1:0] ACTIVE_RST   = 4'd8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_SELF_TAG     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ACTIVE_SLOTS = 2'd1;

  // Result outcome codes.
  localparam logic [OUTCOME_BITS-1:0] OUT_MATCH = 2'd0;
  localparam logic [OUTCOME_BITS-1:0] OUT_EMPTY = 2'd1;
  localparam logic [OUTCOME_BITS-1:0] OUT_EVICT = 2'd2;
  localparam logic [OUTCOME_BITS-1:0] OUT_DROP  = 2'd3;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_e;

endpackage

### rtl/tstl_ram.sv
`timescale 1ns / 1ps

module tstl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### rtl/tag_slot_table_lru.sv
`timescale 1ns / 1ps

// Sender tag table with oldest-stamp replacement.
// Input channel: vehicle_id_i is taken at a clock edge with start_i high and
// busy_o low. One result per input: slot_o and outcome_o are shown for one
// cycle with done_o high; the receiver cannot stall, so nothing is held off.
// An ID whose first byte equals the self tag is dropped: its result appears
// on the next cycle and busy_o stays low.
// Any other ID scans the active slots one entry per cycle through the
// registered read port of the slot memory, then does the write-back. The
// scan stops at the first slot that is empty or matches; otherwise it reads
// all n active slots and evicts, where n is active_slots clamped to 1..SLOTS.
// busy_o falls as the result shows, so the next ID can be taken at the edge
// that takes the result. No new ID is taken during a scan or write-back.
// The memory read pipeline sets the pace.
// Configuration: cfg_valid_i with cfg_index_i/cfg_data_i, always ready;
// write only while busy_o is low. Index 0 is the self tag, 1 the number of
// active slots; other indexes are ignored.
// Reset clears the per-slot valid flags, so every slot reads as empty with a
// zero stamp right away; the write counter restarts at one and the
// registers return to self tag 66 and eight active slots.
module tag_slot_table_lru
  import tstl_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int ID_BYTES   = ID_BYTES_DEF,
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [VID_BITS-1:0]      vehicle_id_i,
  output logic                     done_o,
  output logic [SLOT_BITS-1:0]     slot_o,
  output logic [OUTCOME_BITS-1:0]  outcome_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int ID_BITS = 8 * ID_BYTES;
  localparam int ENT_W   = ID_BITS + STAMP_BITS;
  localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

  state_e state_q, state_d;

  logic [IDX_W-1:0]        cmp_q, cmp_d;
  logic [IDX_W-1:0]        chosen_q, chosen_d;
  logic [IDX_W-1:0]        best_idx_q, best_idx_d;
  logic [STAMP_BITS-1:0]   best_q, best_d;
  logic [OUTCOME_BITS-1:0] kind_q, kind_d;
  logic [ID_BITS-1:0]      id_q, id_d;
  logic [STAMP_BITS-1:0]   counter_q, counter_d;
  logic [SLOTS-1:0]        valid_q;
  logic [7:0]              self_tag_q;
  logic [ACTIVE_BITS-1:0]  active_q;
  logic                    done_q, done_d;
  logic [SLOT_BITS-1:0]    slot_q, slot_d;
  logic [OUTCOME_BITS-1:0] outcome_q, outcome_d;

  logic                    ram_we, ram_re;
  logic [IDX_W-1:0]        ram_raddr;
  logic [ENT_W-1:0]        ram_rdata;

  logic [ID_BITS-1:0]      id_norm;
  logic [CNT_W-1:0]        used;
  logic [IDX_W-1:0]        last_idx;
  logic [ID_BITS-1:0]      ent_id;
  logic [STAMP_BITS-1:0]   ent_stamp;
  logic                    take_new;
  logic [STAMP_BITS-1:0]   best_now;
  logic [IDX_W-1:0]        best_now_idx;

  // Slot memory: normalized ID over write stamp.
  tstl_ram #(
    .WIDTH(ENT_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(chosen_q),
    .wdata_i({id_q, counter_q}),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Keep ID bytes up to the first zero byte.
  always_comb begin
    logic alive;
    alive   = 1'b1;
    id_norm = '0;
    for (int b = 0; b < ID_BYTES; b++) begin
      if (vehicle_id_i[8*b +: 8] == 8'd0) begin
        alive = 1'b0;
      end
      if (alive) begin
        id_norm[8*b +: 8] = vehicle_id_i[8*b +: 8];
      end
    end
  end

  // Number of slots in use, clamped to the table.
  always_comb begin
    if (active_q == '0) begin
      used = CNT_W'(1);
    end else if (32'(active_q) > SLOTS) begin
      used = CNT_W'(SLOTS);
    end else begin
      used = CNT_W'(active_q);
    end
    last_idx = IDX_W'(used - 1'b1);
  end

  // Entry under compare; a slot never written since reset reads as zero.
  assign ent_id    = valid_q[cmp_q] ? ram_rdata[ENT_W-1:STAMP_BITS] : '0;
  assign ent_stamp = valid_q[cmp_q] ? ram_rdata[STAMP_BITS-1:0] : '0;

  // Running oldest stamp, ties kept at the lower index.
  assign take_new     = (cmp_q == '0) || (ent_stamp < best_q);
  assign best_now     = take_new ? ent_stamp : best_q;
  assign best_now_idx = take_new ? cmp_q : best_idx_q;

  // Next state and datapath.
  always_comb begin
    state_d    = state_q;
    cmp_d      = cmp_q;
    chosen_d   = chosen_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    kind_d     = kind_q;
    id_d       = id_q;
    counter_d  = counter_q;
    done_d     = 1'b0;
    slot_d     = slot_q;
    outcome_d  = outcome_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (vehicle_id_i[7:0] == self_tag_q) begin
            done_d    = 1'b1;
            slot_d    = '0;
            outcome_d = OUT_DROP;
          end else begin
            id_d    = id_norm;
            cmp_d   = '0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        best_d     = best_now;
        best_idx_d = best_now_idx;
        if (ent_id[7:0] == 8'd0) begin
          chosen_d = cmp_q;
          kind_d   = OUT_EMPTY;
          state_d  = ST_WRITE;
        end else if (ent_id == id_q) begin
          chosen_d = cmp_q;
          kind_d   = OUT_MATCH;
          state_d  = ST_WRITE;
        end else if (cmp_q == last_idx) begin
          chosen_d = best_now_idx;
          kind_d   = OUT_EVICT;
          state_d  = ST_WRITE;
        end else begin
          cmp_d = cmp_q + 1'b1;
        end
      end
      ST_WRITE: begin
        done_d    = 1'b1;
        slot_d    = SLOT_BITS'(chosen_q);
        outcome_d = kind_q;
        if (counter_q != STAMP_MAX) begin
          counter_d = counter_q + 1'b1;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Memory control and handshake outputs.
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    ram_we    = 1'b0;
    busy_o    = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        ram_re = start_i;
      end
      ST_SCAN: begin
        ram_re    = 1'b1;
        ram_raddr = cmp_q + 1'b1;
      end
      ST_WRITE: begin
        ram_we = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign slot_o      = slot_q;
  assign outcome_o   = outcome_q;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      counter_q <= STAMP_BITS'(1);
      valid_q   <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      counter_q <= counter_d;
      done_q    <= done_d;
      if (ram_we) begin
        valid_q[chosen_q] <= 1'b1;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_tag_q <= SELF_TAG_RST;
      active_q   <= ACTIVE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SELF_TAG:     self_tag_q <= cfg_data_i;
        CFG_ACTIVE_SLOTS: active_q   <= cfg_data_i[ACTIVE_BITS-1:0];
        default:          ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmp_q      <= cmp_d;
    chosen_q   <= chosen_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    kind_q     <= kind_d;
    id_q       <= id_d;
    slot_q     <= slot_d;
    outcome_q  <= outcome_d;
  end

endmodule

### rtl/tstl_checker.sv
`timescale 1ns / 1ps

module tstl_checker
  import tstl_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start_i,
  input logic                    busy_o,
  input logic                    done_o,
  input logic [SLOT_BITS-1:0]    slot_o,
  input logic [OUTCOME_BITS-1:0] outcome_o
);

  // An accepted beat either starts a scan or is dropped with a result.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("accepted beat neither started a scan nor returned a result");

  // The end of a scan always delivers its result.
  a_scan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("scan ended without a result strobe");

  // Results appear only while the block is idle.
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // A dropped beat reports slot zero.
  a_drop_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (outcome_o == OUT_DROP)) |-> (slot_o == '0))
    else $error("dropped beat with nonzero slot");

endmodule

bind tag_slot_table_lru tstl_checker u_tstl_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .done_o   (done_o),
  .slot_o   (slot_o),
  .outcome_o(outcome_o)
);
